[rtl/core/kwm_pkg.sv]
// kwm_pkg: shared types and constants for the k-way merge block
// no dependencies
`default_nettype none
package kwm_pkg;
	localparam int MAX_RUNS     = 16;
	localparam int BUFFER_DEPTH = 4096;
	localparam int RUN_W        = $clog2(MAX_RUNS);
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int RUNS_W       = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 17;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_DEFINE = 2'd1;
	localparam logic [1:0] OP_MERGE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_RUNS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_COLS  = 2'd2;

	localparam logic [16:0] PREV_NONE = 17'h1FFFF;
	localparam logic [16:0] PREV_SAT  = 17'h1FFFE;

	typedef struct packed {
		logic [1:0]  op;
		logic [11:0] position;
		logic [31:0] index_value;
		logic [3:0]  run_id;
		logic [11:0] run_start;
		logic [12:0] run_length;
	} in_beat_t;

	typedef struct packed {
		logic        element_valid;
		logic [11:0] source_position;
		logic [16:0] row_one_based;
		logic [15:0] column;
		logic        column_start;
		logic [12:0] column_pointer;
		logic        done_res;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_DIV, ST_EMIT, ST_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [16:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quot;
		logic [16:0] rem;
	} div_rsp_t;
endpackage
`default_nettype wire

[rtl/core/kwm_divider.sv]
// kwm_divider: radix-2 restoring divider, one quotient bit per cycle
// depends on kwm_pkg
`default_nettype none
module kwm_divider (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire kwm_pkg::div_req_t req,
	output kwm_pkg::div_rsp_t     rsp
);
	import kwm_pkg::*;

	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [31:0] quot_q;
	logic [17:0] rem_q;
	logic [16:0] dsr_q;
	logic [17:0] trial;

	assign trial = {rem_q[16:0], quot_q[31]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dsr_q  <= (req.divisor == '0) ? 17'd1 : req.divisor;
		end else if (busy_q) begin
			if (!trial[17]) begin
				rem_q  <= trial;
				quot_q <= {quot_q[30:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[16:0], quot_q[31]};
				quot_q <= {quot_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q[16:0];
endmodule
`default_nettype wire

[rtl/core/kway_merge_to_ccs_builder.sv]
// kway_merge_to_ccs_builder: k-way merge of linear indices into column order
// depends on kwm_pkg, kwm_divider
//
//  channel | dir | signals
//  in      | in  | in_valid, in_ready, in_data (in_beat_t)
//  out     | out | out_valid, out_ready, out_data (out_beat_t)
//  cfg     | in  | cfg_we, cfg_index, cfg_data
//
// load, define and unknown beats pass through scan_rd and out before out_valid
// a merge step checks run heads in scan_cmp, live ones in scan_rd (one read port),
// then picks, divides in the serial divider and emits (straight to out when done)
// the result sits in an output register; the next item waits until it is taken
// reset clears run table, counters and control; the buffer is never cleared
`default_nettype none
module kway_merge_to_ccs_builder (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire kwm_pkg::in_beat_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output kwm_pkg::out_beat_t       out_data,
	input  wire logic                cfg_we,
	input  wire logic [kwm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [kwm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kwm_pkg::*;

	logic [31:0] mem [BUFFER_DEPTH];
	logic [31:0] rd_q;
	logic [ADDR_W-1:0] rd_addr;
	logic        rd_en;

	logic [11:0] next_slot_q [MAX_RUNS];
	logic [12:0] remain_q [MAX_RUNS];
	logic [12:0] count_q;
	logic [16:0] prev_col_q;
	logic [16:0] msize_q;
	logic [RUNS_W-1:0] nruns_q;
	logic [15:0] ncols_q;

	state_t state_q, state_d;
	in_beat_t in_q;
	logic [RUNS_W-1:0] r_q;
	logic [RUN_W-1:0] best_q;
	logic [31:0] best_val_q;
	logic found_q;
	out_beat_t res_q;
	logic out_valid_q;

	div_req_t dreq;
	div_rsp_t drsp;

	logic [RUNS_W-1:0] runs_eff;
	assign runs_eff = (nruns_q > RUNS_W'(MAX_RUNS)) ? RUNS_W'(MAX_RUNS) : nruns_q;

	kwm_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msize_q <= 17'd1;
			nruns_q <= 5'd1;
			ncols_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MATRIX_SIZE: msize_q <= cfg_data;
				CFG_NUM_RUNS:    nruns_q <= cfg_data[RUNS_W-1:0];
				CFG_LOCAL_COLS:  ncols_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign rd_addr = next_slot_q[r_q[RUN_W-1:0]][ADDR_W-1:0];
	assign rd_en   = (state_q == ST_SCAN_CMP);

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN_RD && in_q.op == OP_LOAD)
			mem[in_q.position[ADDR_W-1:0]] <= in_q.index_value;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		dreq = '{start: 1'b0, dividend: best_val_q, divisor: msize_q};
		unique case (state_q)
			ST_IDLE: if (in_valid && !out_valid_q) state_d = (in_data.op == OP_MERGE) ?
				ST_SCAN_CMP : ST_SCAN_RD;
			ST_SCAN_RD:
				state_d = (in_q.op == OP_MERGE) ? ST_SCAN_CMP : ST_OUT;
			ST_SCAN_CMP: begin
				if (r_q >= runs_eff) begin
					if (found_q) begin
						dreq.start = 1'b1;
						state_d = ST_DIV;
					end else state_d = ST_OUT;
				end else if (remain_q[r_q[RUN_W-1:0]] != '0) state_d = ST_SCAN_RD;
			end
			ST_DIV:  if (drsp.done) state_d = ST_EMIT;
			ST_EMIT: state_d = ST_OUT;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	logic first_cmp;
	assign first_cmp = (state_q == ST_SCAN_CMP) && (r_q < runs_eff)
		&& (remain_q[r_q[RUN_W-1:0]] == '0);

	logic [16:0] colc;
	logic opens;
	assign colc  = (drsp.quot > 32'(PREV_SAT)) ? PREV_SAT : drsp.quot[16:0];
	assign opens = (prev_col_q == PREV_NONE) || (colc > prev_col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			prev_col_q  <= PREV_NONE;
			found_q     <= 1'b0;
			r_q         <= '0;
			best_q      <= '0;
			for (int i = 0; i < MAX_RUNS; i++) begin
				next_slot_q[i] <= '0;
				remain_q[i]    <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid && !out_valid_q) begin
					r_q     <= '0;
					found_q <= 1'b0;
				end
				ST_SCAN_RD: if (in_q.op == OP_DEFINE) begin
					if (32'(in_q.run_id) < MAX_RUNS) begin
						next_slot_q[in_q.run_id[RUN_W-1:0]] <= in_q.run_start;
						remain_q[in_q.run_id[RUN_W-1:0]]    <= in_q.run_length;
					end
					count_q    <= '0;
					prev_col_q <= PREV_NONE;
				end
				ST_SCAN_CMP: begin
					if (first_cmp) r_q <= r_q + 5'd1;
					else if (r_q < runs_eff && state_d == ST_SCAN_RD) ;
				end
				ST_EMIT: begin
					next_slot_q[best_q] <= next_slot_q[best_q] + 12'd1;
					remain_q[best_q]    <= remain_q[best_q] - 13'd1;
					count_q             <= count_q + 13'd1;
					if (opens) prev_col_q <= colc;
				end
				ST_OUT: out_valid_q <= 1'b1;
				default: ;
			endcase
			if (state_q == ST_SCAN_RD && in_q.op == OP_MERGE) begin
				r_q <= r_q + 5'd1;
				if (!found_q || rd_q < best_val_q) begin
					found_q <= 1'b1;
					best_q  <= r_q[RUN_W-1:0];
				end
			end
		end
	end

	// head read in scan_cmp, compared in scan_rd
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && !out_valid_q) begin
			in_q  <= in_data;
			res_q <= '0;
		end
		if (state_q == ST_SCAN_RD && in_q.op == OP_MERGE)
			if (!found_q || rd_q < best_val_q) best_val_q <= rd_q;
		if (state_q == ST_SCAN_CMP && r_q >= runs_eff && !found_q) begin
			res_q.column         <= ncols_q;
			res_q.column_start   <= 1'b1;
			res_q.column_pointer <= count_q + 13'd1;
			res_q.done_res       <= 1'b1;
		end
		if (state_q == ST_EMIT) begin
			res_q.element_valid   <= 1'b1;
			res_q.source_position <= next_slot_q[best_q];
			res_q.row_one_based   <= drsp.rem + 17'd1;
			res_q.column          <= drsp.quot[15:0];
			res_q.column_start    <= opens;
			res_q.column_pointer  <= count_q + 13'd1;
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_one_hot_res: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.element_valid && out_data.done_res))
		else $error("element and done together");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire
